### sv/assert_macros.svh
// Assertion macros shared by the range lookup RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define SRMT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define SRMT_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define SRMT_ASSERT(lbl, clk, rstn, prop, msg)
`define SRMT_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

### sv/srmt_pkg.sv
// Package for the smallest range match tagger: types, codes and constants.
// No dependencies; used by controller, datapath and top level.
`timescale 1ns / 1ps
package srmt_pkg;

  localparam int unsigned ADDR_W       = 64;
  localparam int unsigned TAG_W        = 8;
  localparam int unsigned SLOT_W       = 4;
  localparam int unsigned ENTRY_W      = 2 * ADDR_W + 2 * TAG_W;
  localparam int unsigned TABLE_SHIFT  = 52;
  localparam int unsigned COLUMN_SHIFT = 48;
  localparam logic [ADDR_W-1:0] MARKER = 64'h0A00_0000_0000_0000;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;     // write one entry from the input ports
    logic start;    // latch lookup address, clear running best
    logic issue;    // read the entry at the scan counter, advance it
    logic publish;  // move the final result into the output register
  } srmt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_issue;  // scan counter sits on the last entry
    logic pipe_busy;   // compare pipeline still holds an entry
    logic out_free;    // output register can take a result this cycle
  } srmt_sts_t;

endpackage

### sv/srmt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module srmt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/srmt_ctrl.sv
// Controller state machine for the range lookup: input handshake and scan sequencing.
// Depends on srmt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module srmt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                func_i,
  output logic                in_ready_o,
  input  srmt_pkg::srmt_sts_t sts_i,
  output srmt_pkg::srmt_cmd_t cmd_o
);

  srmt_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srmt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      srmt_pkg::ST_IDLE: begin
        if (in_valid_i && (func_i == srmt_pkg::FUNC_LOOKUP)) begin
          state_d = srmt_pkg::ST_SCAN;
        end
      end
      srmt_pkg::ST_SCAN: begin
        if (sts_i.last_issue) begin
          state_d = srmt_pkg::ST_DRAIN;
        end
      end
      srmt_pkg::ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = srmt_pkg::ST_DONE;
        end
      end
      srmt_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          state_d = srmt_pkg::ST_IDLE;
        end
      end
      default: state_d = srmt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      srmt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load  = (func_i == srmt_pkg::FUNC_LOAD);
          cmd_o.start = (func_i == srmt_pkg::FUNC_LOOKUP);
        end
      end
      srmt_pkg::ST_SCAN: begin
        cmd_o.issue = 1'b1;
      end
      srmt_pkg::ST_DRAIN: begin
      end
      srmt_pkg::ST_DONE: begin
        cmd_o.publish = sts_i.out_free;
      end
      default: begin
      end
    endcase
  end

  // pipeline must be empty whenever a new item can enter
  `SRMT_ASSERT(a_idle_pipe_empty, clk_i, rst_ni,
    (state_q == srmt_pkg::ST_IDLE) |-> !sts_i.pipe_busy, "pipeline busy in idle")
  // result is only taken once every entry has been compared
  `SRMT_ASSERT(a_done_pipe_empty, clk_i, rst_ni,
    (state_q == srmt_pkg::ST_DONE) |-> !sts_i.pipe_busy, "result taken before drain")
  // scan ends only after the last entry was issued
  `SRMT_ASSERT(a_scan_complete, clk_i, rst_ni,
    ((state_q == srmt_pkg::ST_DRAIN) && ($past(state_q) == srmt_pkg::ST_SCAN))
      |-> $past(sts_i.last_issue), "scan left early")

endmodule

### sv/srmt_dpath.sv
// Datapath for the range lookup: entry RAM, valid bits, compare pipeline, output register.
// Depends on srmt_pkg, srmt_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module srmt_dpath #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  srmt_pkg::srmt_cmd_t                 cmd_i,
  output srmt_pkg::srmt_sts_t                 sts_o,
  input  logic [srmt_pkg::SLOT_W-1:0]         entry_index_i,
  input  logic [srmt_pkg::ADDR_W-1:0]         range_start_i,
  input  logic [srmt_pkg::ADDR_W-1:0]         range_end_i,
  input  logic [srmt_pkg::TAG_W-1:0]          table_tag_i,
  input  logic [srmt_pkg::TAG_W-1:0]          column_tag_i,
  input  logic [srmt_pkg::ADDR_W-1:0]         lookup_address_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [srmt_pkg::ADDR_W-1:0]         tagged_address_o,
  output logic                                hit_o,
  output logic [srmt_pkg::SLOT_W-1:0]         matched_entry_o
);
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned EXT_W = (IDX_W > srmt_pkg::SLOT_W) ? IDX_W : srmt_pkg::SLOT_W;
  localparam int unsigned AW    = srmt_pkg::ADDR_W;
  localparam int unsigned TW    = srmt_pkg::TAG_W;

  // ---- load path ----
  logic [EXT_W-1:0]             slot_ext;
  logic                         slot_ok;
  logic                         wr_en;
  logic [IDX_W-1:0]             wr_addr;
  logic [srmt_pkg::ENTRY_W-1:0] wr_data;
  logic [ENTRIES-1:0]           valid_q;

  assign slot_ext = EXT_W'(entry_index_i);
  assign slot_ok  = (32'(entry_index_i) < 32'(ENTRIES));
  assign wr_en    = cmd_i.load && slot_ok;
  assign wr_addr  = slot_ext[IDX_W-1:0];
  assign wr_data  = {range_start_i, range_end_i, table_tag_i, column_tag_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[wr_addr] <= 1'b1;
    end
  end

  // ---- scan counter and RAM read ----
  logic [IDX_W-1:0]             cnt_q, cnt_d;
  logic [srmt_pkg::ENTRY_W-1:0] rd_data;

  assign cnt_d = cmd_i.start ? '0 : (cmd_i.issue ? cnt_q + IDX_W'(1) : cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  srmt_ram #(
    .WIDTH (srmt_pkg::ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (cmd_i.issue),
    .raddr_i (cnt_q),
    .rdata_o (rd_data)
  );

  // stage 1: RAM data out, valid bit and index alongside
  logic             s1_vld_q;
  logic             s1_ent_vld_q;
  logic [IDX_W-1:0] s1_idx_q;
  logic [AW-1:0]    s1_low, s1_high;
  logic [TW-1:0]    s1_tt, s1_ct;

  assign {s1_low, s1_high, s1_tt, s1_ct} = rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= cmd_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      s1_ent_vld_q <= valid_q[cnt_q];
      s1_idx_q     <= cnt_q;
    end
  end

  // stage 2: containment test and span
  logic             s2_vld_q;
  logic             s2_match_q;
  logic [AW-1:0]    s2_span_q;
  logic [IDX_W-1:0] s2_idx_q;
  logic [TW-1:0]    s2_tt_q, s2_ct_q;
  logic [AW-1:0]    addr_q;
  logic             s1_match;

  assign s1_match = s1_ent_vld_q && (addr_q >= s1_low) && (addr_q <= s1_high);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      s2_match_q <= s1_match;
      s2_span_q  <= s1_high - s1_low;
      s2_idx_q   <= s1_idx_q;
      s2_tt_q    <= s1_tt;
      s2_ct_q    <= s1_ct;
    end
  end

  // stage 3: running best, strict compare keeps the lowest index on a tie
  logic             found_q;
  logic [AW-1:0]    best_span_q;
  logic [IDX_W-1:0] best_idx_q;
  logic [TW-1:0]    best_tt_q, best_ct_q;
  logic             take;

  assign take = s2_vld_q && s2_match_q && (!found_q || (s2_span_q < best_span_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.start) begin
      found_q <= 1'b0;
    end else if (take) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      addr_q <= lookup_address_i;
    end
    if (take) begin
      best_span_q <= s2_span_q;
      best_idx_q  <= s2_idx_q;
      best_tt_q   <= s2_tt_q;
      best_ct_q   <= s2_ct_q;
    end
  end

  // ---- output register ----
  logic                           out_valid_q;
  logic [AW-1:0]                  out_addr_q;
  logic                           out_hit_q;
  logic [srmt_pkg::SLOT_W-1:0]    out_match_q;
  logic [EXT_W-1:0]               best_idx_ext;
  logic [AW-1:0]                  tag_addr;

  assign best_idx_ext = EXT_W'(best_idx_q);
  assign tag_addr = addr_q | srmt_pkg::MARKER
                  | (AW'(best_tt_q) << srmt_pkg::TABLE_SHIFT)
                  | (AW'(best_ct_q) << srmt_pkg::COLUMN_SHIFT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_addr_q  <= found_q ? tag_addr : addr_q;
      out_hit_q   <= found_q;
      out_match_q <= found_q ? best_idx_ext[srmt_pkg::SLOT_W-1:0] : '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign tagged_address_o = out_addr_q;
  assign hit_o            = out_hit_q;
  assign matched_entry_o  = out_match_q;

  assign sts_o.last_issue = (cnt_q == IDX_W'(ENTRIES - 1));
  assign sts_o.pipe_busy  = s1_vld_q || s2_vld_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // stage 2 is only ever filled from stage 1
  `SRMT_ASSERT(a_s2_from_s1, clk_i, rst_ni,
    s2_vld_q |-> $past(s1_vld_q), "stage 2 filled without stage 1")
  // a miss reports entry zero
  `SRMT_ASSERT(a_miss_entry_zero, clk_i, rst_ni,
    (out_valid_q && !out_hit_q) |-> (out_match_q == '0), "miss with nonzero entry")
  // a stalled result stays put until it is taken
  `SRMT_ASSERT(a_out_hold, clk_i, rst_ni,
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_addr_q)), "result dropped")

endmodule

### sv/smallest_range_match_tagger.sv
// Top level of the smallest range match tagger.
// Depends on srmt_pkg, srmt_ctrl, srmt_dpath (and through it srmt_ram).
`timescale 1ns / 1ps
// Usage:
// - One input channel (in_valid_i / in_ready_o) carries two kinds of transaction:
//   func_i = 0 loads one table entry (bounds, table tag, column tag) and marks it
//   valid; func_i = 1 looks up lookup_address_i. Loads give no result.
// - One output channel (out_valid_o / out_ready_i) returns one transaction per
//   lookup: the tagged address, a hit flag and the winning entry index.
// - A load leaves the controller in idle, so in_ready_o stays high.
// - A lookup reads the entry RAM once per entry through its single read port.
//   The controller then waits in its drain state until the read and compare
//   stages are empty, and in its done state moves the result into the output
//   register; in_ready_o stays low from acceptance until it is back in idle,
//   so a new transaction is not taken until the lookup is through.
// - If the receiver stalls, the result waits in the output register; further
//   loads and a new lookup scan still proceed, and a finished lookup then waits
//   until the output register frees up before the input side reopens.
// - Reset clears all valid bits, the controller and the output valid; entry
//   contents are not cleared, since only valid entries are ever compared.
module smallest_range_match_tagger #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        func_i,
  input  logic [srmt_pkg::SLOT_W-1:0] entry_index_i,
  input  logic [srmt_pkg::ADDR_W-1:0] range_start_i,
  input  logic [srmt_pkg::ADDR_W-1:0] range_end_i,
  input  logic [srmt_pkg::TAG_W-1:0]  table_tag_i,
  input  logic [srmt_pkg::TAG_W-1:0]  column_tag_i,
  input  logic [srmt_pkg::ADDR_W-1:0] lookup_address_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [srmt_pkg::ADDR_W-1:0] tagged_address_o,
  output logic                        hit_o,
  output logic [srmt_pkg::SLOT_W-1:0] matched_entry_o
);

  // command and status between the sequencer and the datapath
  srmt_pkg::srmt_cmd_t cmd;
  srmt_pkg::srmt_sts_t sts;

  srmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // entry RAM, valid bits, three-stage compare and output register
  srmt_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .entry_index_i    (entry_index_i),
    .range_start_i    (range_start_i),
    .range_end_i      (range_end_i),
    .table_tag_i      (table_tag_i),
    .column_tag_i     (column_tag_i),
    .lookup_address_i (lookup_address_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .tagged_address_o (tagged_address_o),
    .hit_o            (hit_o),
    .matched_entry_o  (matched_entry_o)
  );

endmodule
